// ===== rtl/d2q9_pkg.sv =====
// ----------------------------------------------------------------------------
// d2q9_pkg
// Shared types, constants and helpers of the D2Q9 BGK collision pipeline.
// ----------------------------------------------------------------------------
package d2q9_pkg;

   localparam int FRAC_BITS   = 28;
   localparam int DATA_W      = 32;
   localparam int OMEGA_W     = 29;
   localparam int LANES       = 9;
   localparam int DIV_STAGES  = 31;
   localparam int MOM_LAT     = 3;
   localparam int LANE_LAT    = 10;
   localparam int E0_IDX      = MOM_LAT + DIV_STAGES + 1;
   localparam int PIPE_LAT    = E0_IDX + 1 + LANE_LAT;
   localparam int RECIP_SHIFT = 37;

   localparam logic [OMEGA_W-1:0] OMEGA_RESET = 29'd479349029;

   typedef logic [LANES-1:0][DATA_W-1:0] dist_vec_type;

   typedef enum logic [1:0] {
      WGT_REST,
      WGT_AXIS,
      WGT_DIAG
   } wgt_type;

   // divider request: magnitudes, result sign and special cases
   typedef struct packed {
      logic [31:0] un;
      logic [31:0] ud;
      logic        neg;
      logic        zero;
      logic        ovf;
   } div_op_type;

   typedef struct packed {
      logic [31:0] rem;
      logic [30:0] quo;
      logic [2:0]  lo;
      logic [31:0] ud;
      logic        neg;
      logic        zero;
      logic        ovf;
   } div_st_type;

   localparam logic signed [1:0] DIR_X [LANES] = '{2'sd0, 2'sd1, 2'sd0, -2'sd1, 2'sd0,
                                                   2'sd1, -2'sd1, -2'sd1, 2'sd1};
   localparam logic signed [1:0] DIR_Y [LANES] = '{2'sd0, 2'sd0, 2'sd1, 2'sd0, -2'sd1,
                                                   2'sd1, 2'sd1, -2'sd1, -2'sd1};

   function automatic wgt_type lane_wgt(input int idx);
      wgt_type w;
      if (idx == 0) w = WGT_REST;
      else if (idx < 5) w = WGT_AXIS;
      else w = WGT_DIAG;
      return w;
   endfunction

   // ceil(2^37 * w) for weights 4/9, 1/9, 1/36
   function automatic logic [35:0] wgt_recip(input wgt_type w);
      logic [35:0] m;
      case (w)
         WGT_REST: m = 36'd61083979321;
         WGT_AXIS: m = 36'd15270994831;
         WGT_DIAG: m = 36'd3817748708;
         default:  m = 36'd15270994831;
      endcase
      return m;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [67:0] x);
      logic signed [31:0] r;
      if (x > 68'sd2147483647) r = 32'sh7fffffff;
      else if (x < -68'sd2147483648) r = 32'sh80000000;
      else r = x[31:0];
      return r;
   endfunction

   function automatic logic signed [35:0] ext36(input logic [31:0] v);
      return 36'(signed'(v));
   endfunction

endpackage

// ===== rtl/d2q9_bgk_collision.sv =====
// ----------------------------------------------------------------------------
// d2q9_bgk_collision
// D2Q9 BGK collision of one lattice cell per request, fixed point Q4.28.
//
//   channel  dir  handshake            payload
//   req      in   req_tvalid/tready    tdata dist_in_0..8, tuser is_solid
//   rsp      out  rsp_tvalid/tready    tdata dist_out_0..8
//   csr      in   csr_wr_en            csr_wr_data omega
//
// One request per cycle sustained while the skid entry is empty; requests pass
// through the 31-stage velocity dividers and the lane pipeline to rsp_tvalid.
// Synchronous active-high reset clears valids; omega resets to 1/0.56.
// A two-entry output skid stalls the pipeline only when both entries are full.
// ----------------------------------------------------------------------------
module d2q9_bgk_collision (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [287:0]                 req_tdata,   // dist_in_0 .. dist_in_8
   input  logic                         req_tuser,   // is_solid
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [287:0]                 rsp_tdata,   // dist_out_0 .. dist_out_8
   input  logic                         csr_wr_en,
   input  logic [d2q9_pkg::OMEGA_W-1:0] csr_wr_data
);

   localparam int LAT = d2q9_pkg::PIPE_LAT;

   logic [d2q9_pkg::OMEGA_W-1:0] omega_ff;
   logic                         en;
   logic                         vld_ff [LAT];
   logic                         solid_ff [LAT];
   d2q9_pkg::dist_vec_type       f_ff [LAT];
   logic signed [31:0]           rho_ff [d2q9_pkg::DIV_STAGES+1];

   d2q9_pkg::div_op_type         div_x, div_y;
   logic signed [31:0]           rho_m, ux, uy;
   logic signed [63:0]           sqx_ff, sqy_ff;
   logic signed [31:0]           u2_ff, u2d_ff;
   logic signed [31:0]           lane_res [d2q9_pkg::LANES];
   logic [287:0]                 tail_data;

   logic                         out_vld_ff, out_vld_in, skid_vld_ff, skid_vld_in;
   logic [287:0]                 out_data_ff, out_data_in, skid_data_ff, skid_data_in;
   logic                         cap, take;

   assign en         = !skid_vld_ff;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) omega_ff <= d2q9_pkg::OMEGA_RESET;
      else if (csr_wr_en) omega_ff <= csr_wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) vld_ff[i] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_tvalid;
         for (int i = 1; i < LAT; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         solid_ff[0] <= req_tuser;
         f_ff[0]     <= req_tdata;
         for (int i = 1; i < LAT; i++) begin
            solid_ff[i] <= solid_ff[i-1];
            f_ff[i]     <= f_ff[i-1];
         end
         rho_ff[0] <= rho_m;
         for (int i = 1; i <= d2q9_pkg::DIV_STAGES; i++) rho_ff[i] <= rho_ff[i-1];
      end
   end

   d2q9_moments u_moments (
      .clock (clock),
      .en    (en),
      .f_in  (f_ff[0]),
      .div_x (div_x),
      .div_y (div_y),
      .rho   (rho_m)
   );

   d2q9_div_lane u_div_x (.clock(clock), .en(en), .op(div_x), .quot(ux));
   d2q9_div_lane u_div_y (.clock(clock), .en(en), .op(div_y), .quot(uy));

   // shared u^2, aligned with the lanes' third stage
   always_ff @(posedge clock) begin
      if (en) begin
         sqx_ff <= 64'(ux) * 64'(ux);
         sqy_ff <= 64'(uy) * 64'(uy);
         u2_ff  <= d2q9_pkg::sat32(
                      68'(d2q9_pkg::sat32(68'(sqx_ff >>> d2q9_pkg::FRAC_BITS)))
                    + 68'(d2q9_pkg::sat32(68'(sqy_ff >>> d2q9_pkg::FRAC_BITS))));
         u2d_ff <= u2_ff;
      end
   end

   for (genvar i = 0; i < d2q9_pkg::LANES; i++) begin : g_lane
      d2q9_eq_lane u_lane (
         .clock    (clock),
         .en       (en),
         .dir_x    (d2q9_pkg::DIR_X[i]),
         .dir_y    (d2q9_pkg::DIR_Y[i]),
         .wgt      (d2q9_pkg::lane_wgt(i)),
         .omega    (omega_ff),
         .ux       (ux),
         .uy       (uy),
         .u2       (u2d_ff),
         .rho      (rho_ff[d2q9_pkg::DIV_STAGES]),
         .f_in     (signed'(f_ff[d2q9_pkg::E0_IDX][i])),
         .dist_out (lane_res[i])
      );
      assign tail_data[i*32 +: 32] = solid_ff[LAT-1] ? f_ff[LAT-1][i] : 32'(lane_res[i]);
   end

   // output register plus skid entry
   always_comb begin
      cap          = vld_ff[LAT-1] && en;
      take         = out_vld_ff && rsp_tready;
      out_vld_in   = out_vld_ff;
      out_data_in  = out_data_ff;
      skid_vld_in  = skid_vld_ff;
      skid_data_in = skid_data_ff;
      if (skid_vld_ff) begin
         if (take) begin
            out_data_in = skid_data_ff;
            skid_vld_in = 1'b0;
         end
      end else if (!out_vld_ff || take) begin
         out_vld_in  = cap;
         out_data_in = tail_data;
      end else if (cap) begin
         skid_vld_in  = 1'b1;
         skid_data_in = tail_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

// ===== rtl/d2q9_moments.sv =====
// ----------------------------------------------------------------------------
// d2q9_moments
// Density and momentum sums, then magnitude and sign setup for the dividers.
// ----------------------------------------------------------------------------
module d2q9_moments (
   input  logic                        clock,
   input  logic                        en,
   input  d2q9_pkg::dist_vec_type      f_in,
   output d2q9_pkg::div_op_type        div_x,
   output d2q9_pkg::div_op_type        div_y,
   output logic signed [31:0]          rho
);

   logic signed [35:0] rest_ff, ex_ff, wx_ff, ny_ff, sy_ff;
   logic signed [31:0] rho_ff, jx_ff, jy_ff;
   logic signed [31:0] rho3_ff;
   d2q9_pkg::div_op_type opx_ff, opy_ff, opx_in, opy_in;
   logic [31:0] ud;

   always_ff @(posedge clock) begin
      if (en) begin
         rest_ff <= d2q9_pkg::ext36(f_in[0]) + d2q9_pkg::ext36(f_in[2])
                  + d2q9_pkg::ext36(f_in[4]);
         ex_ff   <= d2q9_pkg::ext36(f_in[1]) + d2q9_pkg::ext36(f_in[5])
                  + d2q9_pkg::ext36(f_in[8]);
         wx_ff   <= d2q9_pkg::ext36(f_in[3]) + d2q9_pkg::ext36(f_in[6])
                  + d2q9_pkg::ext36(f_in[7]);
         ny_ff   <= d2q9_pkg::ext36(f_in[2]) + d2q9_pkg::ext36(f_in[5])
                  + d2q9_pkg::ext36(f_in[6]);
         sy_ff   <= d2q9_pkg::ext36(f_in[4]) + d2q9_pkg::ext36(f_in[7])
                  + d2q9_pkg::ext36(f_in[8]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rho_ff <= d2q9_pkg::sat32(68'(rest_ff + ex_ff + wx_ff));
         jx_ff  <= d2q9_pkg::sat32(68'(ex_ff - wx_ff));
         jy_ff  <= d2q9_pkg::sat32(68'(ny_ff - sy_ff));
      end
   end

   always_comb begin
      ud = rho_ff[31] ? 32'(-rho_ff) : 32'(rho_ff);
      opx_in.un   = jx_ff[31] ? 32'(-jx_ff) : 32'(jx_ff);
      opx_in.ud   = ud;
      opx_in.neg  = jx_ff[31] ^ rho_ff[31];
      opx_in.zero = (rho_ff == 32'sd0);
      opx_in.ovf  = {3'b000, opx_in.un} >= {ud, 3'b000};
      opy_in.un   = jy_ff[31] ? 32'(-jy_ff) : 32'(jy_ff);
      opy_in.ud   = ud;
      opy_in.neg  = jy_ff[31] ^ rho_ff[31];
      opy_in.zero = (rho_ff == 32'sd0);
      opy_in.ovf  = {3'b000, opy_in.un} >= {ud, 3'b000};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         opx_ff  <= opx_in;
         opy_ff  <= opy_in;
         rho3_ff <= rho_ff;
      end
   end

   assign div_x = opx_ff;
   assign div_y = opy_ff;
   assign rho   = rho3_ff;

endmodule

// ===== rtl/d2q9_div_lane.sv =====
// ----------------------------------------------------------------------------
// d2q9_div_lane
// Pipelined restoring divider, one quotient bit per stage, saturating output.
// ----------------------------------------------------------------------------
module d2q9_div_lane (
   input  logic                  clock,
   input  logic                  en,
   input  d2q9_pkg::div_op_type  op,
   output logic signed [31:0]    quot
);

   d2q9_pkg::div_st_type st_ff [d2q9_pkg::DIV_STAGES];
   d2q9_pkg::div_st_type init;
   logic signed [31:0]   quot_ff, quot_in;
   logic [31:0]          mag;
   logic signed [32:0]   sval;

   always_comb begin
      init.rem  = {3'b000, op.un[31:3]};
      init.quo  = '0;
      init.lo   = op.un[2:0];
      init.ud   = op.ud;
      init.neg  = op.neg;
      init.zero = op.zero;
      init.ovf  = op.ovf;
   end

   for (genvar k = 0; k < d2q9_pkg::DIV_STAGES; k++) begin : g_stage
      d2q9_pkg::div_st_type prev, nxt;
      logic [32:0] trial;
      logic        ge;
      if (k == 0) begin : g_first
         assign prev = init;
      end else begin : g_next
         assign prev = st_ff[k-1];
      end
      always_comb begin
         trial = {prev.rem, prev.lo[2]};
         ge    = trial >= {1'b0, prev.ud};
         nxt   = prev;
         nxt.rem = ge ? 32'(trial - {1'b0, prev.ud}) : trial[31:0];
         nxt.quo = {prev.quo[29:0], ge};
         nxt.lo  = {prev.lo[1:0], 1'b0};
      end
      always_ff @(posedge clock) begin
         if (en) st_ff[k] <= nxt;
      end
   end

   always_comb begin
      mag  = st_ff[d2q9_pkg::DIV_STAGES-1].ovf ? 32'h80000000
                                                : {1'b0, st_ff[d2q9_pkg::DIV_STAGES-1].quo};
      sval = st_ff[d2q9_pkg::DIV_STAGES-1].neg ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
      quot_in = st_ff[d2q9_pkg::DIV_STAGES-1].zero ? 32'sd0 : d2q9_pkg::sat32(68'(sval));
   end

   always_ff @(posedge clock) begin
      if (en) quot_ff <= quot_in;
   end

   assign quot = quot_ff;

endmodule

// ===== rtl/d2q9_eq_lane.sv =====
// ----------------------------------------------------------------------------
// d2q9_eq_lane
// One direction: equilibrium value and BGK relaxation of its distribution.
// ----------------------------------------------------------------------------
module d2q9_eq_lane (
   input  logic                         clock,
   input  logic                         en,
   input  logic signed [1:0]            dir_x,
   input  logic signed [1:0]            dir_y,
   input  d2q9_pkg::wgt_type            wgt,
   input  logic [d2q9_pkg::OMEGA_W-1:0] omega,
   input  logic signed [31:0]           ux,
   input  logic signed [31:0]           uy,
   input  logic signed [31:0]           u2,
   input  logic signed [31:0]           rho,
   input  logic signed [31:0]           f_in,
   output logic signed [31:0]           dist_out
);

   localparam int F = d2q9_pkg::FRAC_BITS;

   logic signed [31:0] f_ff [9];
   logic signed [31:0] rho_ff [4];
   logic signed [31:0] cu_ff, cu1_ff, cu2d_ff, cu2_ff, br_ff, p_ff, res_ff;
   logic signed [63:0] cu2p_ff, pp_ff, rp_ff;
   logic [67:0]        wp_ff;
   logic               neg_ff;
   logic signed [33:0] diff_ff;

   logic signed [33:0] px, py;
   logic signed [39:0] c40, k40, u40, br40;
   logic [31:0]        amag;
   logic signed [33:0] qs, feq;
   logic signed [29:0] om_s;
   logic signed [63:0] rel;

   always_comb begin
      case (dir_x)
         2'sd1:   px = 34'(ux);
         -2'sd1:  px = -34'(ux);
         default: px = '0;
      endcase
      case (dir_y)
         2'sd1:   py = 34'(uy);
         -2'sd1:  py = -34'(uy);
         default: py = '0;
      endcase
      c40  = 40'(cu2d_ff);
      k40  = 40'(cu2_ff);
      u40  = 40'(u2);
      br40 = (40'sd1 <<< F) + (c40 <<< 1) + c40 + (((k40 <<< 3) + k40) >>> 1)
           - (((u40 <<< 1) + u40) >>> 1);
      amag = p_ff[31] ? 32'(-p_ff) : 32'(p_ff);
      qs   = signed'(34'(wp_ff[67:d2q9_pkg::RECIP_SHIFT]));
      feq  = neg_ff ? -qs : qs;
      om_s = signed'({1'b0, omega});
      rel  = rp_ff >>> F;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f_ff[0] <= f_in;
         for (int i = 1; i < 9; i++) f_ff[i] <= f_ff[i-1];
         rho_ff[0] <= rho;
         for (int i = 1; i < 4; i++) rho_ff[i] <= rho_ff[i-1];
         // E1..E4
         cu_ff   <= d2q9_pkg::sat32(68'(px + py));
         cu2p_ff <= 64'(cu_ff) * 64'(cu_ff);
         cu1_ff  <= cu_ff;
         cu2_ff  <= d2q9_pkg::sat32(68'(cu2p_ff >>> F));
         cu2d_ff <= cu1_ff;
         br_ff   <= d2q9_pkg::sat32(68'(br40));
         // E5..E7
         pp_ff   <= 64'(rho_ff[3]) * 64'(br_ff);
         p_ff    <= d2q9_pkg::sat32(68'(pp_ff >>> F));
         wp_ff   <= 68'(amag) * 68'(d2q9_pkg::wgt_recip(wgt));
         neg_ff  <= p_ff[31];
         // E8..E10
         diff_ff <= 34'(f_ff[6]) - feq;
         rp_ff   <= 64'(om_s) * 64'(diff_ff);
         res_ff  <= d2q9_pkg::sat32(68'(f_ff[8]) - 68'(rel));
      end
   end

   assign dist_out = res_ff;

endmodule

// ===== verif/tb_d2q9_bgk_collision.sv =====
// ----------------------------------------------------------------------------
// tb_d2q9_bgk_collision
// Streams lattice cells through the collision block: directed corner cells,
// then near-equilibrium and wide random cells under several omega settings.
// Each response is compared lane by lane against a bit-exact predictor.
// ----------------------------------------------------------------------------
class collision_scoreboard;
   logic [d2q9_pkg::OMEGA_W-1:0] omega;
   logic [287:0]                 pending[$];
   int                           accepted;
   int                           errors;

   function new();
      omega    = d2q9_pkg::OMEGA_RESET;
      accepted = 0;
      errors   = 0;
   endfunction

   function automatic longint clip32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   function automatic longint qmul(longint a, longint b);
      return clip32((a * b) >>> d2q9_pkg::FRAC_BITS);
   endfunction

   function automatic longint qdiv(longint n, longint d);
      bit     neg;
      bit     big;
      longint un, ud, q, r;
      big = 0;
      if (d == 0) return 0;
      neg = (n < 0) != (d < 0);
      un  = n < 0 ? -n : n;
      ud  = d < 0 ? -d : d;
      q   = un / ud;
      r   = un % ud;
      for (int k = 0; k < d2q9_pkg::FRAC_BITS; k++) begin
         if (q > 64'h80000000) begin
            big = 1;
            break;
         end
         q = q << 1;
         r = r << 1;
         if (r >= ud) begin
            r = r - ud;
            q = q | 1;
         end
      end
      if (big || q > 64'h80000000) q = 64'h80000001;
      return clip32(neg ? -q : q);
   endfunction

   function automatic logic [287:0] collide(logic [287:0] d, bit solid);
      longint       f[9];
      longint       rho, jx, jy, ux, uy, u2, cu, cu2, br, p, feq, rel;
      logic [287:0] r;
      rho = 0;
      jx  = 0;
      jy  = 0;
      for (int i = 0; i < 9; i++) begin
         f[i] = longint'(signed'(d[32*i +: 32]));
         rho += f[i];
         jx  += f[i] * d2q9_pkg::DIR_X[i];
         jy  += f[i] * d2q9_pkg::DIR_Y[i];
      end
      if (solid) return d;
      rho = clip32(rho);
      jx  = clip32(jx);
      jy  = clip32(jy);
      ux  = qdiv(jx, rho);
      uy  = qdiv(jy, rho);
      u2  = clip32(qmul(ux, ux) + qmul(uy, uy));
      for (int i = 0; i < 9; i++) begin
         cu  = clip32(d2q9_pkg::DIR_X[i] * ux + d2q9_pkg::DIR_Y[i] * uy);
         cu2 = qmul(cu, cu);
         br  = (64'sd1 <<< d2q9_pkg::FRAC_BITS) + 3 * cu + ((9 * cu2) >>> 1)
               - ((3 * u2) >>> 1);
         br  = clip32(br);
         p   = qmul(rho, br);
         case (d2q9_pkg::lane_wgt(i))
            d2q9_pkg::WGT_REST: feq = (4 * p) / 9;
            d2q9_pkg::WGT_AXIS: feq = p / 9;
            default:            feq = p / 36;
         endcase
         rel = (longint'({35'd0, omega}) * (f[i] - feq)) >>> 28;
         r[32*i +: 32] = 32'(clip32(f[i] - rel));
      end
      return r;
   endfunction

   function void note_cell(logic [287:0] d, bit solid);
      pending.push_back(collide(d, solid));
      accepted++;
   endfunction

   function void check_cell(logic [287:0] got);
      logic [287:0] want;
      if (pending.size() == 0) begin
         $display("%0t: unexpected response %h", $time, got);
         errors++;
         return;
      end
      want = pending.pop_front();
      for (int i = 0; i < 9; i++)
         if (want[32*i +: 32] !== got[32*i +: 32]) begin
            $display("%0t: dist_out_%0d expected %h actual %h", $time, i,
                     want[32*i +: 32], got[32*i +: 32]);
            errors++;
         end
   endfunction
endclass

module tb_d2q9_bgk_collision;

   localparam int WATCHDOG = 5000;

   logic                          clock = 0;
   logic                          reset = 1;
   logic                          req_tvalid = 0;
   logic                          req_tready;
   logic [287:0]                  req_tdata = '0;   // dist_in_0 .. dist_in_8
   logic                          req_tuser = 0;    // is_solid
   logic                          rsp_tvalid;
   logic                          rsp_tready = 0;
   logic [287:0]                  rsp_tdata;        // dist_out_0 .. dist_out_8
   logic                          csr_wr_en = 0;
   logic [d2q9_pkg::OMEGA_W-1:0]  csr_wr_data = '0;

   collision_scoreboard sb = new();
   int                  burst_left = 0;
   int                  stall_cnt = 0;
   int                  hold_left = 0;
   bit                  held = 0;
   int                  quiet = 0;

   d2q9_bgk_collision dut (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   // receiver: changing stall modes, plus one long hold-off
   always @(posedge clock) begin
      if (!held && sb.accepted >= 300) begin
         held = 1;
         hold_left = 400;
      end
      stall_cnt++;
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 0;
      end else begin
         case ((stall_cnt / 128) % 3)
            0: rsp_tready <= 1;
            1: rsp_tready <= ($urandom % 4) != 0;
            default: rsp_tready <= $urandom % 2;
         endcase
      end
   end

   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready) sb.check_cell(rsp_tdata);

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG) begin
         $display("d2q9_bgk_collision verification failed");
         $finish;
      end
   end

   task automatic send_cell(logic [287:0] d, bit solid);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         burst_left = $urandom_range(1, 40);
         if (gap > 0) begin
            req_tvalid <= 0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1;
      req_tdata  <= d;
      req_tuser  <= solid;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_cell(d, solid);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      burst_left = 0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (d2q9_pkg::PIPE_LAT + 4) @(posedge clock);
   endtask

   task automatic write_omega(logic [d2q9_pkg::OMEGA_W-1:0] v);
      drain();
      csr_wr_en   <= 1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 0;
      sb.omega = v;
   endtask

   function automatic logic [287:0] fill(logic [31:0] v);
      logic [287:0] d;
      for (int i = 0; i < 9; i++) d[32*i +: 32] = v;
      return d;
   endfunction

   function automatic logic [287:0] random_cell();
      logic [287:0] d;
      int           kind;
      int           bias;
      kind = $urandom_range(0, 9);
      bias = $urandom_range(0, 8);
      for (int i = 0; i < 9; i++) begin
         if (kind < 6) begin
            case (d2q9_pkg::lane_wgt(i))
               d2q9_pkg::WGT_REST: d[32*i +: 32] = 32'd119304647;
               d2q9_pkg::WGT_AXIS: d[32*i +: 32] = 32'd29826162;
               default:            d[32*i +: 32] = 32'd7456540;
            endcase
            d[32*i +: 32] = d[32*i +: 32] + $signed($urandom_range(0, 1 << 23)) - (1 << 22);
            if (i == bias) d[32*i +: 32] = d[32*i +: 32] + $urandom_range(0, 1 << 25);
         end else if (kind < 8) begin
            d[32*i +: 32] = $signed($urandom_range(0, 1 << 31)) - (1 << 30);
         end else begin
            d[32*i +: 32] = $urandom;
         end
      end
      return d;
   endfunction

   initial begin
      logic [287:0] d;
      logic [d2q9_pkg::OMEGA_W-1:0] omegas[4];
      omegas = '{29'd0, 29'h1fffffff, 29'd268435456, d2q9_pkg::OMEGA_RESET};

      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed corners
      send_cell(fill(32'h0), 0);                         // zero density
      send_cell(fill(32'h7fffffff), 0);
      send_cell(fill(32'h80000000), 0);
      send_cell(fill(32'h80000000), 1);
      send_cell(fill(32'h7fffffff), 1);
      send_cell(fill(32'hffffffff), 0);                  // negative density
      send_cell(fill(32'hf0000000), 0);
      d = '0;
      d[32*1 +: 32] = 32'h7fffffff;
      d[32*3 +: 32] = 32'h00000001;
      send_cell(d, 0);                                   // density saturation
      d = '0;
      d[32*2 +: 32] = 32'h10000000;
      d[32*4 +: 32] = 32'hf0000001;
      send_cell(d, 0);
      d = '0;
      d[32*0 +: 32] = 32'd119304647;
      for (int i = 1; i < 5; i++) d[32*i +: 32] = 32'd29826162;
      for (int i = 5; i < 9; i++) d[32*i +: 32] = 32'd7456540;
      send_cell(d, 0);                                   // rest equilibrium
      for (int i = 1; i < 9; i++) begin
         d = '0;
         d[32*i +: 32] = 32'h10000000;
         send_cell(d, 0);
      end
      send_cell(fill(32'h55555555), 0);
      send_cell(fill(32'haaaaaaaa), 0);

      for (int n = 0; n < 400; n++) send_cell(random_cell(), ($urandom % 8) == 0);
      foreach (omegas[k]) begin
         write_omega(omegas[k]);
         send_cell(fill(32'h7fffffff), 0);
         send_cell(fill(32'h80000000), 0);
         for (int n = 0; n < 280; n++) send_cell(random_cell(), ($urandom % 8) == 0);
      end
      write_omega(29'($urandom_range(0, 29'h1fffffff)));
      for (int n = 0; n < 100; n++) send_cell(random_cell(), ($urandom % 8) == 0);
      drain();

      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("d2q9_bgk_collision verification clean");
      else
         $display("d2q9_bgk_collision verification failed");
      $finish;
   end
endmodule

// ===== sim.f =====
rtl/d2q9_pkg.sv
rtl/d2q9_moments.sv
rtl/d2q9_div_lane.sv
rtl/d2q9_eq_lane.sv
rtl/d2q9_bgk_collision.sv
verif/tb_d2q9_bgk_collision.sv
